FILE: hw/rtl/sliding_window_median_limit_macros.svh
// assertion macros for the sliding window median limit block
// no dependencies; included by the modules that carry assertions
`ifndef SLIDING_WINDOW_MEDIAN_LIMIT_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_LIMIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SWML_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SWML_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/swml_pkg.sv
// shared types and constants of the sliding window median limit block
// no dependencies
`timescale 1ns / 1ps

package swml_pkg;

    localparam int SIZE_W     = 32;
    localparam int MULT_W     = 8;
    localparam int PROD_W     = SIZE_W + MULT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MULTIPLE = 2'd1;

    // register reset values
    localparam logic [SIZE_W-1:0] MIN_LIMIT_RST = 32'd1000000;
    localparam logic [MULT_W-1:0] MULT_RST      = 8'd2;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_RING,
        TS_SORT,
        TS_LIMIT,
        TS_PUSH
    } t_top_state;

    typedef enum logic [2:0] {
        SS_IDLE,
        SS_RM,
        SS_INS,
        SS_FIX,
        SS_MA,
        SS_MB,
        SS_MC
    } t_sort_state;

    typedef struct packed {
        logic              start;
        logic              remove;
        logic [SIZE_W-1:0] old_size;
        logic [SIZE_W-1:0] new_size;
    } t_sort_req;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] median;
    } t_sort_rsp;

    typedef struct packed {
        logic [SIZE_W-1:0] limit;
        logic [SIZE_W-1:0] median;
        logic              window_full;
    } t_lim_res;

endpackage

FILE: hw/rtl/swml_sorter.sv
// sorted store with remove and insert passes and median read-out
// depends on swml_pkg and sliding_window_median_limit_macros.svh
`timescale 1ns / 1ps
`include "sliding_window_median_limit_macros.svh"

module swml_sorter #(
    parameter int WINDOW = 64,
    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    localparam int CW = $clog2(WINDOW + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swml_pkg::t_sort_req  i_req,
    input  logic [CW-1:0]        i_fill,
    output swml_pkg::t_sort_rsp  o_rsp
);

    localparam logic [AW-1:0] LAST    = AW'(WINDOW - 1);
    localparam logic [AW-1:0] RM_NEXT = AW'((WINDOW > 1) ? WINDOW - 2 : 0);
    localparam logic [AW-1:0] HALF_HI = AW'(WINDOW / 2);
    localparam logic [AW-1:0] HALF_LO = AW'((WINDOW / 2 > 0) ? WINDOW / 2 - 1 : 0);
    localparam bit            EVEN    = (WINDOW % 2) == 0;

    logic [swml_pkg::SIZE_W-1:0] r_mem [WINDOW];

    swml_pkg::t_sort_state r_state, n_state;
    logic [AW-1:0]               r_idx, n_idx, r_idx_d;
    logic                        r_issue, n_issue;
    logic                        r_found, n_found;
    logic                        r_vld_d;
    logic                        r_done;
    logic [swml_pkg::SIZE_W-1:0] r_old, r_new, r_rd_data, r_hi, r_median, n_median;

    logic                        w_we;
    logic [AW-1:0]               w_wa;
    logic [swml_pkg::SIZE_W-1:0] w_wd;
    logic [AW-1:0]               w_ra;
    logic                        w_rd_en;
    logic                        w_lt;
    logic [swml_pkg::SIZE_W:0]   w_sum;

    assign w_lt  = r_rd_data < r_new;
    assign w_sum = {1'b0, r_hi} + {1'b0, r_rd_data};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swml_pkg::SS_IDLE: begin
                if (i_req.start) begin
                    if (i_req.remove) begin
                        n_state = swml_pkg::SS_RM;
                    end else if (i_fill == '0) begin
                        n_state = swml_pkg::SS_FIX;
                    end else begin
                        n_state = swml_pkg::SS_INS;
                    end
                end
            end
            swml_pkg::SS_RM: begin
                if (r_vld_d && r_idx_d == LAST) begin
                    n_state = (WINDOW > 1) ? swml_pkg::SS_INS : swml_pkg::SS_FIX;
                end
            end
            swml_pkg::SS_INS: begin
                if (r_vld_d) begin
                    if (w_lt) begin
                        n_state = swml_pkg::SS_MA;
                    end else if (r_idx_d == '0) begin
                        n_state = swml_pkg::SS_FIX;
                    end
                end
            end
            swml_pkg::SS_FIX: n_state = swml_pkg::SS_MA;
            swml_pkg::SS_MA:  n_state = swml_pkg::SS_MB;
            swml_pkg::SS_MB:  n_state = swml_pkg::SS_MC;
            swml_pkg::SS_MC:  n_state = swml_pkg::SS_IDLE;
            default:          n_state = swml_pkg::SS_IDLE;
        endcase
    end

    // memory ports and pass counters
    always_comb begin
        n_idx    = r_idx;
        n_issue  = r_issue;
        n_found  = r_found;
        n_median = r_median;
        w_we     = 1'b0;
        w_wa     = r_idx_d;
        w_wd     = r_rd_data;
        w_ra     = r_idx;
        w_rd_en  = 1'b0;
        unique case (r_state)
            swml_pkg::SS_IDLE: begin
                if (i_req.start) begin
                    n_found = 1'b0;
                    n_issue = 1'b1;
                    n_idx   = i_req.remove ? '0 : AW'(i_fill - CW'(1));
                end
            end
            swml_pkg::SS_RM: begin
                // forward scan; once the old size is found, each later entry moves down one
                w_rd_en = r_issue;
                if (r_issue) begin
                    if (r_idx == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
                if (r_vld_d) begin
                    if (r_found) begin
                        w_we = 1'b1;
                        w_wa = r_idx_d - AW'(1);
                    end else if (r_rd_data == r_old) begin
                        n_found = 1'b1;
                    end
                    if (r_idx_d == LAST) begin
                        n_idx   = RM_NEXT;
                        n_issue = 1'b1;
                    end
                end
            end
            swml_pkg::SS_INS: begin
                // backward scan; larger entries move up until the new size fits
                w_rd_en = r_issue;
                if (r_issue) begin
                    if (r_idx == '0) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end
                if (r_vld_d) begin
                    w_we = 1'b1;
                    w_wa = r_idx_d + AW'(1);
                    w_wd = w_lt ? r_new : r_rd_data;
                end
            end
            swml_pkg::SS_FIX: begin
                w_we = 1'b1;
                w_wa = '0;
                w_wd = r_new;
            end
            swml_pkg::SS_MA: w_ra = HALF_HI;
            swml_pkg::SS_MB: w_ra = HALF_LO;
            swml_pkg::SS_MC: begin
                n_median = EVEN ? w_sum[swml_pkg::SIZE_W:1] : r_hi;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_idx_d  <= r_idx;
        r_median <= n_median;
        if (r_state == swml_pkg::SS_MB) begin
            r_hi <= r_rd_data;
        end
        if (r_state == swml_pkg::SS_IDLE && i_req.start) begin
            r_old <= i_req.old_size;
            r_new <= i_req.new_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swml_pkg::SS_IDLE;
            r_issue <= 1'b0;
            r_found <= 1'b0;
            r_vld_d <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            r_found <= n_found;
            r_vld_d <= w_rd_en;
            r_done  <= (r_state == swml_pkg::SS_MC);
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.median = r_median;

    `SWML_ASSERT_NOW(a_start_when_idle, i_clk, i_rst_n, i_req.start, r_state == swml_pkg::SS_IDLE, "sort request while busy")
    `SWML_ASSERT_NOW(a_done_in_idle, i_clk, i_rst_n, r_done, r_state == swml_pkg::SS_IDLE, "done outside idle")
    `SWML_ASSERT_NEXT(a_rm_ends, i_clk, i_rst_n, r_state == swml_pkg::SS_RM && r_vld_d && r_idx_d == LAST, r_state != swml_pkg::SS_RM, "remove pass overran")

endmodule

FILE: hw/rtl/swml_limit.sv
// limit arithmetic: median times multiple, saturated, floored at the minimum
// depends on swml_pkg
`timescale 1ns / 1ps

module swml_limit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [swml_pkg::SIZE_W-1:0]   i_median,
    input  logic                          i_full,
    input  logic [swml_pkg::SIZE_W-1:0]   i_min_limit,
    input  logic [swml_pkg::MULT_W-1:0]   i_multiple,
    output logic                          o_valid,
    output swml_pkg::t_lim_res            o_res
);

    logic [swml_pkg::PROD_W-1:0] r_prod;
    logic [swml_pkg::SIZE_W-1:0] r_med;
    logic                        r_full;
    logic                        r_v1, r_v2;
    swml_pkg::t_lim_res          r_res;

    logic [swml_pkg::SIZE_W-1:0] w_sat;
    logic [swml_pkg::SIZE_W-1:0] w_limit;

    assign w_sat   = (|r_prod[swml_pkg::PROD_W-1:swml_pkg::SIZE_W]) ? '1
                                                                    : r_prod[swml_pkg::SIZE_W-1:0];
    assign w_limit = (!r_full || r_med == '0 || w_sat < i_min_limit) ? i_min_limit : w_sat;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= swml_pkg::PROD_W'(i_median) * swml_pkg::PROD_W'(i_multiple);
            r_med  <= i_median;
            r_full <= i_full;
        end
        if (r_v1) begin
            r_res.limit       <= w_limit;
            r_res.median      <= r_full ? r_med : '0;
            r_res.window_full <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/sliding_window_median_limit.sv
// top level of the sliding window median limit block: arrival ring, control, output word
// depends on swml_pkg, swml_sorter, swml_limit and sliding_window_median_limit_macros.svh
`timescale 1ns / 1ps
`include "sliding_window_median_limit_macros.svh"

// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_new_size
// output  | out       | o_out_valid / i_out_ready  | o_limit, o_median, o_window_full
// config  | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// one word at a time; the time per word is set by the remove pass and the insert pass over
// the sorted store, one entry per cycle through its port
// the insert pass stops early once the new size has found its place
// synchronous active-low reset clears control and configuration; the stores need no clearing
// a finished word waits in the output register while the next word is taken in

module sliding_window_median_limit #(
    parameter int WINDOW = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [swml_pkg::SIZE_W-1:0]       i_new_size,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [swml_pkg::SIZE_W-1:0]       o_limit,
    output logic [swml_pkg::SIZE_W-1:0]       o_median,
    output logic                              o_window_full,
    input  logic                              i_cfg_we,
    input  logic [swml_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swml_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int            AW       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int            CW       = $clog2(WINDOW + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW);
    localparam logic [AW-1:0] LAST_PTR = AW'(WINDOW - 1);

    // arrival ring, one read and one write port
    logic [swml_pkg::SIZE_W-1:0] r_ring [WINDOW];
    logic [swml_pkg::SIZE_W-1:0] r_ring_q;

    swml_pkg::t_top_state r_state, n_state;

    logic [CW-1:0]               r_fill, n_fill;
    logic [AW-1:0]               r_ptr, n_ptr;
    logic [swml_pkg::SIZE_W-1:0] r_new_size;
    logic                        r_item_full;

    // configuration registers
    logic [swml_pkg::SIZE_W-1:0] r_min_limit;
    logic [swml_pkg::MULT_W-1:0] r_size_multiple;

    // output register
    logic                        r_out_valid, n_out_valid;
    swml_pkg::t_lim_res          r_out;

    swml_pkg::t_sort_req w_req;
    swml_pkg::t_sort_rsp w_rsp;
    logic                w_lim_valid;
    swml_pkg::t_lim_res  w_lim_res;
    logic                w_accept;
    logic                w_load;
    logic                w_ring_we;

    assign w_accept = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swml_pkg::TS_IDLE:  if (w_accept) n_state = swml_pkg::TS_RING;
            swml_pkg::TS_RING:  n_state = swml_pkg::TS_SORT;
            swml_pkg::TS_SORT:  if (w_rsp.done) n_state = swml_pkg::TS_LIMIT;
            swml_pkg::TS_LIMIT: if (w_lim_valid) n_state = swml_pkg::TS_PUSH;
            swml_pkg::TS_PUSH:  if (!r_out_valid || i_out_ready) n_state = swml_pkg::TS_IDLE;
            default:            n_state = swml_pkg::TS_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready     = 1'b0;
        w_req.start    = 1'b0;
        w_req.remove   = (r_fill == FULL_CNT);
        w_req.old_size = r_ring_q;
        w_req.new_size = r_new_size;
        w_ring_we      = 1'b0;
        w_load         = 1'b0;
        n_fill         = r_fill;
        n_ptr          = r_ptr;
        unique case (r_state)
            swml_pkg::TS_IDLE: o_in_ready = 1'b1;
            swml_pkg::TS_RING: begin
                // the ring read of the slot being replaced is already back
                w_req.start = 1'b1;
                w_ring_we   = 1'b1;
                n_ptr       = (r_ptr == LAST_PTR) ? '0 : r_ptr + AW'(1);
                if (r_fill != FULL_CNT) begin
                    n_fill = r_fill + CW'(1);
                end
            end
            swml_pkg::TS_PUSH: w_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // output valid: set on load, dropped once the word is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[r_ptr] <= r_new_size;
        end
        r_ring_q <= r_ring[r_ptr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_new_size <= i_new_size;
        end
        if (r_state == swml_pkg::TS_RING) begin
            r_item_full <= (r_fill >= FULL_CNT - CW'(1));
        end
        if (w_load) begin
            r_out <= w_lim_res;
        end
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= swml_pkg::TS_IDLE;
            r_fill          <= '0;
            r_ptr           <= '0;
            r_out_valid     <= 1'b0;
            r_min_limit     <= swml_pkg::MIN_LIMIT_RST;
            r_size_multiple <= swml_pkg::MULT_RST;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    swml_pkg::CFG_MIN_LIMIT:     r_min_limit <= i_cfg_data[swml_pkg::SIZE_W-1:0];
                    swml_pkg::CFG_SIZE_MULTIPLE: r_size_multiple <= i_cfg_data[swml_pkg::MULT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    swml_sorter #(
        .WINDOW (WINDOW)
    ) u_sorter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_fill  (r_fill),
        .o_rsp   (w_rsp)
    );

    swml_limit u_limit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_rsp.done),
        .i_median    (w_rsp.median),
        .i_full      (r_item_full),
        .i_min_limit (r_min_limit),
        .i_multiple  (r_size_multiple),
        .o_valid     (w_lim_valid),
        .o_res       (w_lim_res)
    );

    assign o_out_valid   = r_out_valid;
    assign o_limit       = r_out.limit;
    assign o_median      = r_out.median;
    assign o_window_full = r_out.window_full;

    `SWML_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FULL_CNT, "fill count beyond window")
    `SWML_ASSERT_NOW(a_sort_done_in_sort, i_clk, i_rst_n, w_rsp.done, r_state == swml_pkg::TS_SORT, "sorter done outside sort wait")
    `SWML_ASSERT_NOW(a_limit_in_limit, i_clk, i_rst_n, w_lim_valid, r_state == swml_pkg::TS_LIMIT, "limit result outside limit wait")
    `SWML_ASSERT_NOW(a_median_zero, i_clk, i_rst_n, o_out_valid && !o_window_full, o_median == '0, "median not zero before window full")

endmodule

FILE: tb/sv/sliding_window_median_limit_checker.sv
// checker for the sliding window median limit block: watches the three ports,
// predicts every output word and compares it field by field
// depends on swml_pkg
`timescale 1ns / 1ps

module sliding_window_median_limit_checker #(
    parameter int WIN = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [swml_pkg::SIZE_W-1:0]      i_new_size,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [swml_pkg::SIZE_W-1:0]      i_limit,
    input  logic [swml_pkg::SIZE_W-1:0]      i_median,
    input  logic                             i_window_full,
    input  logic                             i_cfg_we,
    input  logic [swml_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swml_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_words_pending
);

    // shadow of the block state
    logic [swml_pkg::SIZE_W-1:0] ring_sizes   [WIN];
    logic [swml_pkg::SIZE_W-1:0] sorted_sizes [WIN];
    int                          held_count;
    int                          ring_slot;
    logic [swml_pkg::SIZE_W-1:0] min_limit_q;
    logic [swml_pkg::MULT_W-1:0] size_multiple_q;

    swml_pkg::t_lim_res expected_words [$];
    int                 mismatch_total;
    int                 pending_count;

    assign o_fail_count    = mismatch_total;
    assign o_words_pending = pending_count;

    function automatic swml_pkg::t_lim_res predict_limit(
        input logic [swml_pkg::SIZE_W-1:0] size);
        swml_pkg::t_lim_res          word;
        logic [swml_pkg::SIZE_W:0]   pair_sum;
        logic [swml_pkg::PROD_W-1:0] product;
        logic [swml_pkg::SIZE_W-1:0] capped;
        int                          pos;
        int                          held;
        int                          i;
        word.limit       = min_limit_q;
        word.median      = '0;
        word.window_full = 1'b0;
        if (held_count == WIN) begin
            // take out one copy of the size leaving the window, else the last entry
            pos = 0;
            while (pos < WIN - 1 && sorted_sizes[pos] != ring_sizes[ring_slot])
                pos++;
            for (i = pos; i < WIN - 1; i++)
                sorted_sizes[i] = sorted_sizes[i + 1];
            held = WIN - 1;
        end else begin
            held = held_count;
            held_count++;
        end
        pos = 0;
        while (pos < held && sorted_sizes[pos] < size)
            pos++;
        for (i = held; i > pos; i--)
            sorted_sizes[i] = sorted_sizes[i - 1];
        sorted_sizes[pos]     = size;
        ring_sizes[ring_slot] = size;
        ring_slot             = (ring_slot + 1) % WIN;

        if (held_count == WIN) begin
            word.window_full = 1'b1;
            if (WIN % 2 == 0) begin
                pair_sum    = {1'b0, sorted_sizes[WIN / 2]} + {1'b0, sorted_sizes[WIN / 2 - 1]};
                word.median = pair_sum[swml_pkg::SIZE_W:1];
            end else begin
                word.median = sorted_sizes[WIN / 2];
            end
            if (word.median != '0) begin
                product = swml_pkg::PROD_W'(word.median) * swml_pkg::PROD_W'(size_multiple_q);
                capped  = (|product[swml_pkg::PROD_W-1:swml_pkg::SIZE_W]) ? '1
                                                                          : product[swml_pkg::SIZE_W-1:0];
                word.limit = (capped < min_limit_q) ? min_limit_q : capped;
            end
        end
        return word;
    endfunction

    task automatic check_field(input string label, input logic [swml_pkg::SIZE_W-1:0] want,
                               input logic [swml_pkg::SIZE_W-1:0] got);
        if (want !== got) begin
            mismatch_total++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label,
                     want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch_edge
        swml_pkg::t_lim_res want;
        if (!i_rst_n) begin
            expected_words.delete();
            held_count      = 0;
            ring_slot       = 0;
            min_limit_q     = swml_pkg::MIN_LIMIT_RST;
            size_multiple_q = swml_pkg::MULT_RST;
            for (int k = 0; k < WIN; k++) begin
                ring_sizes[k]   = '0;
                sorted_sizes[k] = '0;
            end
        end else begin
            // an output word leaving now belongs to an earlier input word
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    mismatch_total++;
                    $display("%0t ns: unexpected word, expected none, actual %h %h %b",
                             $time, i_limit, i_median, i_window_full);
                end else begin
                    want = expected_words.pop_front();
                    check_field("limit", want.limit, i_limit);
                    check_field("median", want.median, i_median);
                    check_field("window_full", swml_pkg::SIZE_W'(want.window_full),
                                swml_pkg::SIZE_W'(i_window_full));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    swml_pkg::CFG_MIN_LIMIT:
                        min_limit_q = i_cfg_data[swml_pkg::SIZE_W-1:0];
                    swml_pkg::CFG_SIZE_MULTIPLE:
                        size_multiple_q = i_cfg_data[swml_pkg::MULT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                want = predict_limit(i_new_size);
                expected_words.insert(expected_words.size(), want);
            end
        end
        pending_count = expected_words.size();
    end

    initial begin
        mismatch_total = 0;
        pending_count  = 0;
    end

endmodule

FILE: tb/sv/tb_sliding_window_median_limit.sv
// top of the sliding window median limit testbench: clock, reset, stimulus and verdict
// depends on swml_pkg, sliding_window_median_limit and sliding_window_median_limit_checker
`timescale 1ns / 1ps

module tb_sliding_window_median_limit;

    localparam int WIN          = 64;
    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 148;
    localparam int PRESSURE_AT  = 300;    // words sent before the long receiver hold-off
    localparam int PRESSURE_LEN = 3000;   // cycles of that hold-off
    localparam int TAIL_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 4000000;

    // indexes the block ignores
    localparam logic [swml_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [swml_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // how the sizes of one phase are drawn
    typedef enum int {
        SZ_ANY,
        SZ_TINY,
        SZ_ZEROS,
        SZ_HUGE,
        SZ_BITS
    } t_size_mix;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [swml_pkg::SIZE_W-1:0]     i_new_size;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [swml_pkg::SIZE_W-1:0]     o_limit;
    logic [swml_pkg::SIZE_W-1:0]     o_median;
    logic                            o_window_full;
    logic                            i_cfg_we;
    logic [swml_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [swml_pkg::CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int words_pending;
    int words_sent;
    int cycle_count;

    // sizes for the opening part, all taken while the window is still filling
    logic [swml_pkg::SIZE_W-1:0] corner_sizes [24] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_0010, 32'h0000_0010, 32'h0000_0010, 32'h000F_4240,
        32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF, 32'h1234_5678,
        32'h0000_0002, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'h0000_0001
    };

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sliding_window_median_limit #(
        .WINDOW (WIN)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_new_size    (i_new_size),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_limit       (o_limit),
        .o_median      (o_median),
        .o_window_full (o_window_full),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sliding_window_median_limit_checker #(
        .WIN (WIN)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_new_size      (i_new_size),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_limit         (o_limit),
        .i_median        (o_median),
        .i_window_full   (o_window_full),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    // idle gap before a word: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else if (r < 97)
            return $urandom_range(5, 20);
        return $urandom_range(30, 200);
    endfunction

    // one size: mostly of the phase's mix, the rest of any mix
    function automatic logic [swml_pkg::SIZE_W-1:0] pick_size(input t_size_mix primary);
        t_size_mix mix;
        int        bit_pos;
        mix     = ($urandom_range(0, 4) == 0) ? t_size_mix'($urandom_range(0, 4)) : primary;
        bit_pos = $urandom_range(0, swml_pkg::SIZE_W - 1);
        case (mix)
            SZ_TINY:  return swml_pkg::SIZE_W'($urandom_range(0, 7));
            SZ_ZEROS: return ($urandom_range(0, 3) != 0) ? '0 : swml_pkg::SIZE_W'($urandom());
            SZ_HUGE:  return swml_pkg::SIZE_W'($urandom()) | 32'hE000_0000;
            SZ_BITS: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return swml_pkg::SIZE_W'(1) << bit_pos;
                    default: return ~(swml_pkg::SIZE_W'(1) << bit_pos);
                endcase
            end
            default:  return swml_pkg::SIZE_W'($urandom());
        endcase
    endfunction

    // offer one word after a gap and hold it until the block takes it
    task automatic send_word(input logic [swml_pkg::SIZE_W-1:0] size, input int gap);
        repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_new_size <= size;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // drop valid and wait until every expected word has come out
    task automatic wait_drained(input int settle);
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (words_pending != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [swml_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swml_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // the multiple register gets junk in the upper bits, which the block drops
    task automatic write_multiple(input logic [swml_pkg::MULT_W-1:0] mult);
        write_reg(swml_pkg::CFG_SIZE_MULTIPLE,
                  (swml_pkg::CFG_DATA_W'($urandom()) & 32'hFFFF_FF00) | mult);
    endtask

    // receiver: random stalls, quiet stretches, and one long hold-off while the
    // sender keeps going so that the block backs up into its input
    initial begin : drain_side
        int stall_left;
        int calm_left;
        int r;
        bit pressure_done;
        i_out_ready   = 1'b0;
        stall_left    = 0;
        calm_left     = 0;
        pressure_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && words_sent >= PRESSURE_AT) begin
                stall_left    = PRESSURE_LEN;
                calm_left     = 0;
                pressure_done = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                i_out_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    calm_left = $urandom_range(200, 800);
                    i_out_ready <= 1'b1;
                end else if (r < 30) begin
                    stall_left = $urandom_range(0, 3);
                    i_out_ready <= 1'b0;
                end else if (r < 32) begin
                    stall_left = $urandom_range(20, 300);
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        t_size_mix mix;
        bit        burst;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_new_size  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        words_sent  = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // opening part at reset register values: extremes while the window fills
        foreach (corner_sizes[k])
            send_word(corner_sizes[k], (k % 3 == 0) ? 0 : gap_len());

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained(4);
            case (phase)
                0: begin
                    write_reg(swml_pkg::CFG_MIN_LIMIT, '0);
                    write_multiple(8'd1);
                    mix = SZ_ANY;
                end
                1: begin
                    // limit pinned at the top
                    write_reg(swml_pkg::CFG_MIN_LIMIT, '1);
                    write_multiple(8'd255);
                    mix = SZ_HUGE;
                end
                2: begin
                    // product overflow saturates
                    write_reg(swml_pkg::CFG_MIN_LIMIT, '0);
                    write_multiple(8'd255);
                    mix = SZ_HUGE;
                end
                3: begin
                    // multiple of zero leaves only the floor
                    write_reg(swml_pkg::CFG_MIN_LIMIT, 32'd1000);
                    write_multiple(8'd0);
                    mix = SZ_ANY;
                end
                4: begin
                    // mostly zeros so the median drops to zero
                    write_reg(swml_pkg::CFG_MIN_LIMIT, swml_pkg::CFG_DATA_W'($urandom()));
                    write_multiple(swml_pkg::MULT_W'($urandom_range(1, 255)));
                    mix = SZ_ZEROS;
                end
                5: begin
                    // many equal sizes in the window
                    write_reg(swml_pkg::CFG_MIN_LIMIT, '0);
                    write_multiple(8'd2);
                    mix = SZ_TINY;
                end
                6: begin
                    write_reg(swml_pkg::CFG_MIN_LIMIT, swml_pkg::CFG_DATA_W'($urandom()));
                    write_multiple(8'd128);
                    mix = SZ_BITS;
                end
                7: begin
                    // writes to unused indexes must change nothing
                    write_reg(CFG_SPARE_A, swml_pkg::CFG_DATA_W'($urandom()));
                    write_reg(CFG_SPARE_B, swml_pkg::CFG_DATA_W'($urandom()));
                    write_reg(swml_pkg::CFG_MIN_LIMIT, 32'd5);
                    write_multiple(8'd3);
                    mix = SZ_ANY;
                end
                8: begin
                    write_reg(swml_pkg::CFG_MIN_LIMIT,
                              swml_pkg::CFG_DATA_W'($urandom_range(0, 50)));
                    write_multiple(swml_pkg::MULT_W'($urandom_range(0, 255)));
                    mix = SZ_TINY;
                end
                default: begin
                    write_reg(swml_pkg::CFG_MIN_LIMIT, swml_pkg::MIN_LIMIT_RST);
                    write_multiple(swml_pkg::MULT_RST);
                    mix = SZ_ANY;
                end
            endcase
            // some phases run back to back with no sender gaps
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_WORDS; k++)
                send_word(pick_size(mix), burst ? 0 : gap_len());
        end

        wait_drained(TAIL_CYCLES);
        if (fail_count == 0 && words_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
